### design/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// sine tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

    // oscillator geometry
    localparam int SINE_DEPTH  = 1024;
    localparam int PHASE_BITS  = 32;
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
    localparam int SINE_ADDR_W = SINE_IDX_W + 1;

    // field widths
    localparam int STEP_W   = 32;
    localparam int MS_W     = 16;
    localparam int AMP_W    = 15;
    localparam int SPT_W    = 11;
    localparam int COUNT_W  = 27;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;

    // command queue between front and back
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_AMPLITUDE = 1'b0;
    localparam logic REG_SPT       = 1'b1;
    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(9830);
    localparam logic [SPT_W-1:0] SPT_RESET = SPT_W'(441);

    // action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // reciprocal of ten for the sample count: floor(x / 10) = (x * RECIP_10) >> 35
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    // table build constants (Q30)
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              action;
        logic [STEP_W-1:0] phase_increment;
        logic [MS_W-1:0]   duration_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_note;
    } t_out_item;

    typedef struct packed {
        logic               action;
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
        logic [QCNT_W-1:0] count;
    } t_q_head;

    typedef logic [MAG_W-1:0] t_sine_rom [0:SINE_DEPTH];

    // round(32767 * sin(x)) for x in Q30 radians, series in nested form
    function automatic logic [MAG_W-1:0] sine_mag(input logic [63:0] x);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] v;
        s = (x * x) >> 30;
        t = Q30_ONE;
        t = Q30_ONE - ((s * t) >> 30) / 64'd156;
        t = Q30_ONE - ((s * t) >> 30) / 64'd110;
        t = Q30_ONE - ((s * t) >> 30) / 64'd72;
        t = Q30_ONE - ((s * t) >> 30) / 64'd42;
        t = Q30_ONE - ((s * t) >> 30) / 64'd20;
        t = Q30_ONE - ((s * t) >> 30) / 64'd6;
        v = (x * t) >> 30;
        v = (v * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

    // quarter-wave table, entries 0..SINE_DEPTH inclusive
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            rom[i] = sine_mag((64'(i) * HALF_PI_Q30) / SINE_DEPTH);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### design/sine_tone_generator.sv
// Path: o_out_valid for a tick rises after the tick passes the two front stages,
// one queue slot, the phase stage, the table read and the scale stage.
// Throughput: one transaction per cycle, set by the phase add
// and the one table read port in the back pipeline; an output stall holds it.
// Reset: synchronous active low, clears queue, note state (idle) and sets
// amplitude to 9830 and samples_per_ten_ms to 441.
// ----------------------------------------------------------------------------
// sine_tone_generator
// Direct digital synthesis sine oscillator with an APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire stg_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output stg_pkg::t_out_item                 o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stg_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [stg_pkg::DATA_W-1:0]    pwdata,
    output logic [stg_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    logic [stg_pkg::AMP_W-1:0] r_amplitude;
    logic [stg_pkg::SPT_W-1:0] r_spt;
    logic                      reg_sel;
    logic                      cfg_wr;

    stg_pkg::t_push   push;
    stg_pkg::t_q_head head;
    logic             pop;

    // register port
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= stg_pkg::AMP_RESET;
            r_spt       <= stg_pkg::SPT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                stg_pkg::REG_AMPLITUDE: r_amplitude <= pwdata[stg_pkg::AMP_W-1:0];
                stg_pkg::REG_SPT:       r_spt       <= pwdata[stg_pkg::SPT_W-1:0];
                default:                r_spt       <= r_spt;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            stg_pkg::REG_AMPLITUDE: prdata = stg_pkg::DATA_W'(r_amplitude);
            stg_pkg::REG_SPT:       prdata = stg_pkg::DATA_W'(r_spt);
            default:                prdata = '0;
        endcase
    end

    // front: accept and size notes
    stg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_spt      (r_spt),
        .i_q_count  (head.count),
        .o_push     (push)
    );

    // command queue
    stg_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head)
    );

    // back: oscillator and sample scaling
    stg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_amplitude (r_amplitude),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### design/stg_front.sv
// ----------------------------------------------------------------------------
// stg_front
// Input side: accepts items, works out the note length in samples for
// start items and pushes commands into the queue in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire stg_pkg::t_in_item              i_in_data,
    input  wire logic [stg_pkg::SPT_W-1:0]      i_spt,
    input  wire logic [stg_pkg::QCNT_W-1:0]     i_q_count,
    output stg_pkg::t_push                      o_push
);

    localparam int PROD_W = stg_pkg::MS_W + stg_pkg::SPT_W;
    localparam int RPROD_W = PROD_W + 32;

    logic                        r_f1_valid;
    logic                        r_f1_action;
    logic [stg_pkg::STEP_W-1:0]  r_f1_step;
    logic [PROD_W-1:0]           r_f1_prod;
    logic                        r_f2_valid;
    stg_pkg::t_cmd               r_f2_cmd;

    logic                        accept;
    logic [stg_pkg::QCNT_W:0]    occupancy;
    logic [RPROD_W-1:0]          recip_prod;

    // credit check: queue entries plus transactions still in the two stages
    assign occupancy = {1'b0, i_q_count} + (stg_pkg::QCNT_W+1)'(r_f1_valid)
                     + (stg_pkg::QCNT_W+1)'(r_f2_valid);
    assign o_in_stall = occupancy >= (stg_pkg::QCNT_W+1)'(stg_pkg::QDEPTH);
    assign accept = i_in_valid && !o_in_stall;

    // divide by ten via reciprocal multiply
    assign recip_prod = RPROD_W'(r_f1_prod) * RPROD_W'(stg_pkg::RECIP_10);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            r_f2_valid <= r_f1_valid;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r_f1_action    <= i_in_data.action;
        r_f1_step      <= i_in_data.phase_increment;
        r_f1_prod      <= PROD_W'(i_in_data.duration_ms) * PROD_W'(i_spt);
        r_f2_cmd.action <= r_f1_action;
        r_f2_cmd.step   <= r_f1_step;
        r_f2_cmd.count  <= stg_pkg::COUNT_W'(recip_prod >> stg_pkg::RECIP_SH);
    end

    assign o_push.valid = r_f2_valid;
    assign o_push.cmd   = r_f2_cmd;

endmodule

`default_nettype wire

### design/stg_cmd_fifo.sv
// ----------------------------------------------------------------------------
// stg_cmd_fifo
// Short command queue that lets the front and back sides stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire stg_pkg::t_push i_push,
    input  wire logic           i_pop,
    output stg_pkg::t_q_head    o_head
);

    stg_pkg::t_cmd                r_mem [stg_pkg::QDEPTH];
    logic [stg_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [stg_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [stg_pkg::QCNT_W-1:0]   r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage, front credit keeps pushes off a full queue
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_head.valid = r_count != '0;
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign o_head.count = r_count;

endmodule

`default_nettype wire

### design/stg_back.sv
// ----------------------------------------------------------------------------
// stg_back
// Oscillator side: holds phase, step and remaining count, looks up the
// quarter-wave table and scales each sample by the amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire stg_pkg::t_q_head            i_head,
    output logic                             o_pop,
    input  wire logic [stg_pkg::AMP_W-1:0]   i_amplitude,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output stg_pkg::t_out_item               o_out_data
);

    localparam int PB     = stg_pkg::PHASE_BITS;
    localparam int IDX_W  = stg_pkg::SINE_IDX_W;
    localparam int ADDR_W = stg_pkg::SINE_ADDR_W;
    localparam int MUL_W  = stg_pkg::AMP_W + stg_pkg::MAG_W + 1;

    localparam stg_pkg::t_sine_rom SINE_ROM = stg_pkg::build_sine_rom();

    logic [PB-1:0]                r_phase;
    logic [stg_pkg::STEP_W-1:0]   r_step;
    logic [stg_pkg::COUNT_W-1:0]  r_left;

    logic                         r_p1_valid;
    logic [ADDR_W-1:0]            r_p1_addr;
    logic                         r_p1_neg;
    logic                         r_p1_mute;
    logic                         r_p1_last;

    logic                         r_p2_valid;
    logic [stg_pkg::MAG_W-1:0]    r_p2_mag;
    logic                         r_p2_neg;
    logic                         r_p2_mute;
    logic                         r_p2_last;

    logic                         r_out_valid;
    stg_pkg::t_out_item           r_out_data;

    logic                         adv;
    logic                         issue;
    logic                         is_start;
    logic [1:0]                   quad;
    logic [IDX_W-1:0]             idx;
    logic [ADDR_W-1:0]            addr;
    logic [MUL_W-1:0]             rounded;
    logic [stg_pkg::SAMPLE_W-1:0] scaled;
    logic signed [stg_pkg::SAMPLE_W-1:0] n_sample;

    // whole back pipeline moves unless a result is held at the output
    assign adv      = !r_out_valid || !i_out_stall;
    assign o_pop    = i_head.valid && adv;
    assign is_start = i_head.cmd.action == stg_pkg::ACT_START;
    assign issue    = o_pop && !is_start && (r_left != '0);

    // table address from the phase, odd quadrants run the table backwards
    assign quad = r_phase[PB-1 -: 2];
    assign idx  = r_phase[PB-3 -: IDX_W];
    assign addr = quad[0] ? ADDR_W'(stg_pkg::SINE_DEPTH) - {1'b0, idx} : {1'b0, idx};

    // scale, round half away from zero, apply sign
    // the product bound keeps the magnitude at or below 32766, no clamp needed
    assign rounded = MUL_W'(i_amplitude) * MUL_W'(r_p2_mag) + MUL_W'(16384);
    assign scaled  = stg_pkg::SAMPLE_W'(rounded >> 15);
    always_comb begin
        if (r_p2_mute) begin
            n_sample = '0;
        end else if (r_p2_neg) begin
            n_sample = -$signed(scaled);
        end else begin
            n_sample = $signed(scaled);
        end
    end

    // note state and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_left      <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            if (o_pop && is_start) begin
                r_step  <= i_head.cmd.step;
                r_phase <= '0;
                r_left  <= i_head.cmd.count;
            end else if (issue) begin
                r_phase <= r_phase + PB'(r_step);
                r_left  <= r_left - 1'b1;
            end
            r_p1_valid  <= issue;
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid;
        end
    end

    // stage payloads and the registered table read
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_addr <= addr;
            r_p1_neg  <= quad[1];
            r_p1_mute <= r_step == '0;
            r_p1_last <= r_left == stg_pkg::COUNT_W'(1);
            r_p2_mag  <= SINE_ROM[r_p1_addr];
            r_p2_neg  <= r_p1_neg;
            r_p2_mute <= r_p1_mute;
            r_p2_last <= r_p1_last;
            r_out_data.sample       <= n_sample;
            r_out_data.last_of_note <= r_p2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### design/stg_checker.sv
// ----------------------------------------------------------------------------
// stg_checker
// Port-level checks for the sine tone generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_in_stall,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire stg_pkg::t_out_item            o_out_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // the pipeline cannot produce a result this soon after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid [*3])
        else $error("result too soon after reset");

    // empty queue right after reset takes input
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // scaled magnitude never reaches full scale negative
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.sample != 16'sh8000)
        else $error("sample out of scaled range");

endmodule

bind sine_tone_generator stg_checker u_stg_checker (.*);

`default_nettype wire
